FILE: hdl/aamd_pkg.sv
package aamd_pkg;

    // Image limits and derived widths
    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int STORE_DEPTH = MAX_WIDTH / 2;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int DIM_W       = 13;
    localparam int CH_W        = 8;
    localparam int ALPHA_LIMIT = 16;
    localparam int ALPHA_DIV_SHIFT = 2;
    localparam int RECIP3      = 683;
    localparam int RECIP3_SHIFT = 11;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_index_t;

    // What the back end does with a queued item
    typedef enum logic [1:0] {
        JOB_STORE,
        JOB_MERGE,
        JOB_WHITE
    } job_kind_t;

    // Sums of one horizontal pixel pair
    typedef struct packed {
        logic [CH_W:0] r;
        logic [CH_W:0] g;
        logic [CH_W:0] b;
        logic [CH_W:0] a;
        logic [1:0]    used;
    } pair_t;

    // Sums of a full 2x2 block
    typedef struct packed {
        logic [CH_W+1:0] r;
        logic [CH_W+1:0] g;
        logic [CH_W+1:0] b;
        logic [CH_W+1:0] a;
        logic [2:0]      used;
    } quad_t;

    typedef struct packed {
        job_kind_t        kind;
        logic [IDX_W-1:0] idx;
        pair_t            pair;
        logic             frame_end;
    } job_t;

    // Truncated mean of a block sum over 0 to 4 used pixels
    function automatic logic [CH_W-1:0] div_used(input logic [CH_W+1:0] sum,
                                                 input logic [2:0] used);
        logic [CH_W+RECIP3_SHIFT:0] prod;
        logic [CH_W-1:0]            q;
        prod = (CH_W+RECIP3_SHIFT+1)'(sum) * (CH_W+RECIP3_SHIFT+1)'(RECIP3);
        unique case (used)
            3'd1:    q = sum[CH_W-1:0];
            3'd2:    q = sum[CH_W:1];
            3'd3:    q = prod[RECIP3_SHIFT+CH_W-1:RECIP3_SHIFT];
            3'd4:    q = sum[CH_W+1:2];
            default: q = '0;
        endcase
        return q;
    endfunction

endpackage

FILE: hdl/aamd_if.sv
interface aamd_pix_if;
    logic                       valid;
    logic                       ready;
    logic [aamd_pkg::CH_W-1:0]  red_in;
    logic [aamd_pkg::CH_W-1:0]  green_in;
    logic [aamd_pkg::CH_W-1:0]  blue_in;
    logic [aamd_pkg::CH_W-1:0]  alpha_in;

    modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface aamd_res_if;
    logic                       valid;
    logic                       ready;
    logic [aamd_pkg::CH_W-1:0]  red_out;
    logic [aamd_pkg::CH_W-1:0]  green_out;
    logic [aamd_pkg::CH_W-1:0]  blue_out;
    logic [aamd_pkg::CH_W-1:0]  alpha_out;
    logic                       frame_end;

    modport source (output valid, red_out, green_out, blue_out, alpha_out, frame_end,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, alpha_out, frame_end,
                    output ready);
endinterface

FILE: hdl/aamd_front.sv
module aamd_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  aamd_pkg::reg_index_t         wr_index,
    input  logic [aamd_pkg::DIM_W-1:0]   wr_data,
    aamd_pix_if.sink                     pixels,
    input  logic                         q_full,
    output logic                         q_push,
    output aamd_pkg::job_t               q_job
);

    logic [aamd_pkg::DIM_W-1:0] width_reg, width_next;
    logic [aamd_pkg::DIM_W-1:0] height_reg, height_next;
    logic [aamd_pkg::COL_W-1:0] col_reg, col_next;
    logic [aamd_pkg::ROW_W-1:0] row_reg, row_next;
    aamd_pkg::pair_t            acc_reg, acc_next;

    logic [aamd_pkg::DIM_W-1:0] w_eff;
    logic [aamd_pkg::DIM_W-1:0] h_eff;
    logic                       accept;
    logic                       w_one, h_one, thin;
    aamd_pkg::pair_t            pix;
    aamd_pkg::pair_t            pair_sum;
    logic [aamd_pkg::DIM_W-1:0] col_inc;
    logic [aamd_pkg::DIM_W-1:0] row_inc;
    logic                       fe;

    assign pixels.ready = !q_full;
    assign accept       = pixels.valid && pixels.ready;

    // Clamp the configured size into the supported range
    always_comb
    begin
        if (width_reg == '0)
            w_eff = aamd_pkg::DIM_W'(1);
        else if (width_reg > aamd_pkg::DIM_W'(aamd_pkg::MAX_WIDTH))
            w_eff = aamd_pkg::DIM_W'(aamd_pkg::MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = aamd_pkg::DIM_W'(1);
        else if (height_reg > aamd_pkg::DIM_W'(aamd_pkg::MAX_HEIGHT))
            h_eff = aamd_pkg::DIM_W'(aamd_pkg::MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    assign w_one = (w_eff == aamd_pkg::DIM_W'(1));
    assign h_one = (h_eff == aamd_pkg::DIM_W'(1));
    assign thin  = w_one || h_one;

    // Mask out pixels that are nearly transparent
    always_comb
    begin
        pix = '0;
        if (pixels.alpha_in >= aamd_pkg::CH_W'(aamd_pkg::ALPHA_LIMIT))
        begin
            pix.r    = {1'b0, pixels.red_in};
            pix.g    = {1'b0, pixels.green_in};
            pix.b    = {1'b0, pixels.blue_in};
            pix.a    = {1'b0, pixels.alpha_in};
            pix.used = 2'd1;
        end
        pair_sum.r    = acc_reg.r + pix.r;
        pair_sum.g    = acc_reg.g + pix.g;
        pair_sum.b    = acc_reg.b + pix.b;
        pair_sum.a    = acc_reg.a + pix.a;
        pair_sum.used = acc_reg.used + pix.used;
    end

    // Last block of the frame: both counters within the final pair
    assign fe = ((aamd_pkg::DIM_W+1)'(col_reg) + (aamd_pkg::DIM_W+1)'(3) >
                 (aamd_pkg::DIM_W+1)'(w_eff)) &&
                ((aamd_pkg::DIM_W+1)'(row_reg) + (aamd_pkg::DIM_W+1)'(3) >
                 (aamd_pkg::DIM_W+1)'(h_eff));

    // Classify the accepted pixel into a job for the back end
    always_comb
    begin
        q_push          = 1'b0;
        q_job.kind      = aamd_pkg::JOB_STORE;
        q_job.idx       = col_reg[aamd_pkg::COL_W-1:1];
        q_job.pair      = pair_sum;
        q_job.frame_end = fe;
        if (accept && !(w_one && h_one))
        begin
            if (thin)
            begin
                if ((w_one || col_reg[0]) && (h_one || row_reg[0]))
                begin
                    q_push     = 1'b1;
                    q_job.kind = aamd_pkg::JOB_WHITE;
                end
            end
            else if (col_reg[0])
            begin
                q_push     = 1'b1;
                q_job.kind = row_reg[0] ? aamd_pkg::JOB_MERGE : aamd_pkg::JOB_STORE;
            end
        end
    end

    // Advance position, hold left pixel, take register writes
    assign col_inc = aamd_pkg::DIM_W'(col_reg) + aamd_pkg::DIM_W'(1);
    assign row_inc = aamd_pkg::DIM_W'(row_reg) + aamd_pkg::DIM_W'(1);

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        acc_next    = acc_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                aamd_pkg::REG_WIDTH:  width_next  = wr_data;
                aamd_pkg::REG_HEIGHT: height_next = wr_data;
            endcase
            col_next = '0;
            row_next = '0;
            acc_next = '0;
        end
        else if (accept)
        begin
            if (!thin && !col_reg[0])
                acc_next = pix;
            if (col_inc >= w_eff)
            begin
                col_next = '0;
                if (row_inc >= h_eff)
                    row_next = '0;
                else
                    row_next = row_inc[aamd_pkg::ROW_W-1:0];
            end
            else
            begin
                col_next = col_inc[aamd_pkg::COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= aamd_pkg::DIM_W'(1);
            height_reg <= aamd_pkg::DIM_W'(1);
            col_reg    <= '0;
            row_reg    <= '0;
            acc_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            acc_reg    <= acc_next;
        end
    end

endmodule

FILE: hdl/aamd_queue.sv
module aamd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  aamd_pkg::job_t  push_job,
    output logic            full,
    input  logic            pop,
    output aamd_pkg::job_t  pop_job,
    output logic            empty
);

    aamd_pkg::job_t                 slots_reg [aamd_pkg::Q_DEPTH];
    logic [aamd_pkg::Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [aamd_pkg::Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [aamd_pkg::Q_CNT_W-1:0]   count_reg, count_next;

    assign full    = (count_reg == aamd_pkg::Q_CNT_W'(aamd_pkg::Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = slots_reg[rd_ptr_reg];

    // Advance pointers and track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed job
    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_job;
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue pushed while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= aamd_pkg::Q_CNT_W'(aamd_pkg::Q_DEPTH))
        else $error("queue count beyond depth");

endmodule

FILE: hdl/aamd_back.sv
module aamd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  aamd_pkg::job_t  q_job,
    output logic            q_pop,
    aamd_res_if.source      results
);

    aamd_pkg::pair_t        store_mem [aamd_pkg::STORE_DEPTH];
    aamd_pkg::pair_t        rd_reg;

    logic                   s1_valid_reg;
    aamd_pkg::job_kind_t    s1_kind_reg;
    aamd_pkg::pair_t        s1_pair_reg;
    logic                   s1_fe_reg;

    logic                   s2_valid_reg;
    aamd_pkg::job_kind_t    s2_kind_reg;
    aamd_pkg::quad_t        s2_sum_reg;
    logic                   s2_fe_reg;

    logic                   res_valid_reg;
    logic [aamd_pkg::CH_W-1:0] red_reg, green_reg, blue_reg, alpha_reg;
    logic                   fe_reg;

    logic                   adv;
    aamd_pkg::quad_t        quad;

    // Whole back end moves when the output register is free
    assign adv   = !res_valid_reg || results.ready;
    assign q_pop = adv && !q_empty;

    // Line store: write top pairs, read them back for the bottom pairs
    always_ff @(posedge clk)
    begin
        if (q_pop && q_job.kind == aamd_pkg::JOB_STORE)
            store_mem[q_job.idx] <= q_job.pair;
        if (q_pop && q_job.kind == aamd_pkg::JOB_MERGE)
            rd_reg <= store_mem[q_job.idx];
    end

    // Add the stored top pair to the bottom pair
    always_comb
    begin
        quad.r    = {1'b0, s1_pair_reg.r} + {1'b0, rd_reg.r};
        quad.g    = {1'b0, s1_pair_reg.g} + {1'b0, rd_reg.g};
        quad.b    = {1'b0, s1_pair_reg.b} + {1'b0, rd_reg.b};
        quad.a    = {1'b0, s1_pair_reg.a} + {1'b0, rd_reg.a};
        quad.used = {1'b0, s1_pair_reg.used} + {1'b0, rd_reg.used};
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= q_pop && (q_job.kind != aamd_pkg::JOB_STORE);
            s2_valid_reg  <= s1_valid_reg;
            res_valid_reg <= s2_valid_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_kind_reg <= q_job.kind;
            s1_pair_reg <= q_job.pair;
            s1_fe_reg   <= q_job.frame_end;
            s2_kind_reg <= s1_kind_reg;
            s2_sum_reg  <= quad;
            s2_fe_reg   <= s1_fe_reg;
            fe_reg      <= s2_fe_reg;
            if (s2_kind_reg == aamd_pkg::JOB_WHITE)
            begin
                red_reg   <= '1;
                green_reg <= '1;
                blue_reg  <= '1;
                alpha_reg <= '1;
            end
            else
            begin
                red_reg   <= aamd_pkg::div_used(s2_sum_reg.r, s2_sum_reg.used);
                green_reg <= aamd_pkg::div_used(s2_sum_reg.g, s2_sum_reg.used);
                blue_reg  <= aamd_pkg::div_used(s2_sum_reg.b, s2_sum_reg.used);
                alpha_reg <= s2_sum_reg.a[aamd_pkg::CH_W+1:aamd_pkg::ALPHA_DIV_SHIFT];
            end
        end
    end

    assign results.valid     = res_valid_reg;
    assign results.red_out   = red_reg;
    assign results.green_out = green_reg;
    assign results.blue_out  = blue_reg;
    assign results.alpha_out = alpha_reg;
    assign results.frame_end = fe_reg;

endmodule

FILE: hdl/alpha_aware_mipmap_downsample.sv
// 2x2 alpha-aware mipmap reducer for a raster-order RGBA pixel stream.
// pixels:  valid/ready channel, one RGBA pixel per item, raster order.
// results: valid/ready channel, one reduced pixel per 2x2 block, raster
//          order, frame_end set on the last pixel of the image.
// wr_en/wr_index/wr_data: write image_width (index 0) or image_height
//          (index 1); any write restarts the frame. Write only while idle.
// Throughput: one pixel per cycle while results are taken; single-port line
//          store takes one top-row write or bottom-row read per cycle.
// Path: the edge that accepts the bottom-right pixel of a block writes its
//          job into the queue; the job then passes the line store read, the
//          block sum and the divide into the output register.
// Reset: size 1x1, position and held pixel cleared; line store contents
//          are undefined but are always written before they are read.
// Stall: when results is not taken the output register holds, the back
//          end freezes, the 4-entry job queue fills and pixels.ready drops.
module alpha_aware_mipmap_downsample (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  aamd_pkg::reg_index_t         wr_index,
    input  logic [aamd_pkg::DIM_W-1:0]   wr_data,
    aamd_pix_if.sink                     pixels,
    aamd_res_if.source                   results
);

    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;
    aamd_pkg::job_t  push_job;
    aamd_pkg::job_t  pop_job;

    aamd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .pixels   (pixels),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    aamd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    aamd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_job    (pop_job),
        .q_pop    (q_pop),
        .results  (results)
    );

endmodule

FILE: sim/tb.sv
module tb;

    localparam int IDLE_LIMIT = 2000;
    localparam int STALL_STRETCH = 300;

    // Running sums of the used pixels of a pair or a block
    typedef struct {
        int unsigned r;
        int unsigned g;
        int unsigned b;
        int unsigned a;
        int unsigned used;
    } channel_sums_t;

    typedef struct {
        logic [aamd_pkg::CH_W-1:0] red;
        logic [aamd_pkg::CH_W-1:0] green;
        logic [aamd_pkg::CH_W-1:0] blue;
        logic [aamd_pkg::CH_W-1:0] alpha;
        logic                      frame_end;
    } mip_pixel_t;

    logic clk = 1'b0;
    logic rst_n;
    logic wr_en;
    aamd_pkg::reg_index_t wr_index;
    logic [aamd_pkg::DIM_W-1:0] wr_data;

    aamd_pix_if pix ();
    aamd_res_if res ();

    alpha_aware_mipmap_downsample dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .pixels   (pix),
        .results  (res)
    );

    always #6 clk = ~clk;

    // Shadow state of the reducer
    logic [aamd_pkg::DIM_W-1:0] width_reg;
    logic [aamd_pkg::DIM_W-1:0] height_reg;
    channel_sums_t    line_sums [aamd_pkg::STORE_DEPTH];
    channel_sums_t    held_left;
    int unsigned      col_pos;
    int unsigned      row_pos;
    mip_pixel_t       pending_pixels [$];

    int  mismatch_count = 0;
    int  idle_cycles = 0;
    bit  src_gaps = 1'b0;
    bit  sink_gaps = 1'b0;
    int  stall_request = 0;

    function automatic int unsigned clamp_dim(input logic [aamd_pkg::DIM_W-1:0] v,
                                              input int unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic channel_sums_t merge_sums(input channel_sums_t x,
                                                 input channel_sums_t y);
        channel_sums_t s;
        s.r = x.r + y.r;
        s.g = x.g + y.g;
        s.b = x.b + y.b;
        s.a = x.a + y.a;
        s.used = x.used + y.used;
        return s;
    endfunction

    function automatic void restart_frame();
        col_pos = 0;
        row_pos = 0;
        held_left = '{default: 0};
    endfunction

    // Fold one pixel into the shadow state; queue the block result it completes
    function automatic void predict_pixel(input logic [aamd_pkg::CH_W-1:0] r,
                                          input logic [aamd_pkg::CH_W-1:0] g,
                                          input logic [aamd_pkg::CH_W-1:0] b,
                                          input logic [aamd_pkg::CH_W-1:0] a);
        int unsigned   w;
        int unsigned   h;
        int unsigned   idx;
        channel_sums_t cur;
        channel_sums_t pair;
        channel_sums_t quad;
        mip_pixel_t    px;
        bit            emit;
        w = clamp_dim(width_reg, aamd_pkg::MAX_WIDTH);
        h = clamp_dim(height_reg, aamd_pkg::MAX_HEIGHT);
        emit = 1'b0;
        px = '{default: '0};
        if (!(w == 1 && h == 1)) begin
            if (w == 1 || h == 1) begin
                // Thin image: opaque white at every second pixel
                if ((w == 1 || col_pos % 2 == 1) && (h == 1 || row_pos % 2 == 1)) begin
                    px.red = '1;
                    px.green = '1;
                    px.blue = '1;
                    px.alpha = '1;
                    emit = 1'b1;
                end
            end
            else begin
                cur = '{default: 0};
                if (a >= aamd_pkg::ALPHA_LIMIT)
                    cur = '{r, g, b, a, 1};
                if (col_pos % 2 == 0) begin
                    held_left = cur;
                end
                else begin
                    pair = merge_sums(held_left, cur);
                    idx = col_pos / 2;
                    if (idx < aamd_pkg::STORE_DEPTH) begin
                        if (row_pos % 2 == 0) begin
                            line_sums[idx] = pair;
                        end
                        else begin
                            quad = merge_sums(pair, line_sums[idx]);
                            if (quad.used > 0) begin
                                px.red = aamd_pkg::CH_W'(quad.r / quad.used);
                                px.green = aamd_pkg::CH_W'(quad.g / quad.used);
                                px.blue = aamd_pkg::CH_W'(quad.b / quad.used);
                            end
                            px.alpha = aamd_pkg::CH_W'(quad.a / 4);
                            emit = 1'b1;
                        end
                    end
                end
            end
            if (emit)
                px.frame_end = (col_pos + 3 > w) && (row_pos + 3 > h);
        end
        if (emit)
            pending_pixels = {pending_pixels, px};
        // Advance the raster position, wrap at the end of the image
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h)
                row_pos = 0;
        end
        col_pos = col_pos & 32'hFFF;
        row_pos = row_pos & 32'hFFF;
    endfunction

    // Track writes and accepted pixels, check each accepted result
    always @(posedge clk or negedge rst_n) begin
        mip_pixel_t got;
        mip_pixel_t want;
        if (!rst_n) begin
            width_reg = 1;
            height_reg = 1;
            foreach (line_sums[i])
                line_sums[i] = '{default: 0};
            restart_frame();
            pending_pixels.delete();
        end
        else begin
            if (res.valid && res.ready) begin
                got = '{res.red_out, res.green_out, res.blue_out, res.alpha_out,
                        res.frame_end};
                if (pending_pixels.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result r=%0d g=%0d b=%0d a=%0d end=%0b",
                                 got.red, got.green, got.blue, got.alpha, got.frame_end);
                end
                else begin
                    want = pending_pixels.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.alpha !== want.alpha ||
                        got.frame_end !== want.frame_end) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: expected r=%0d g=%0d b=%0d a=%0d end=%0b,",
                                      " got r=%0d g=%0d b=%0d a=%0d end=%0b"},
                                     want.red, want.green, want.blue, want.alpha,
                                     want.frame_end, got.red, got.green, got.blue,
                                     got.alpha, got.frame_end);
                    end
                end
            end
            if (wr_en) begin
                if (wr_index == aamd_pkg::REG_WIDTH)
                    width_reg = wr_data;
                else if (wr_index == aamd_pkg::REG_HEIGHT)
                    height_reg = wr_data;
                restart_frame();
            end
            if (pix.valid && pix.ready)
                predict_pixel(pix.red_in, pix.green_in, pix.blue_in, pix.alpha_in);
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk) begin
        if ((pix.valid && pix.ready) || (res.valid && res.ready) || wr_en) begin
            idle_cycles <= 0;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Result side: random hold-offs, one long stall on request
    initial begin : result_sink
        int gap;
        res.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever begin
            gap = sink_gaps ? $urandom_range(0, 13) : 0;
            if (stall_request > 0) begin
                gap = stall_request;
                stall_request = 0;
            end
            if (gap > 0) begin
                res.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(res.valid && res.ready));
        end
    end

    task automatic send_pixel(input logic [aamd_pkg::CH_W-1:0] r,
                              input logic [aamd_pkg::CH_W-1:0] g,
                              input logic [aamd_pkg::CH_W-1:0] b,
                              input logic [aamd_pkg::CH_W-1:0] a);
        int gap;
        gap = src_gaps ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix.valid <= 1'b1;
        pix.red_in <= r;
        pix.green_in <= g;
        pix.blue_in <= b;
        pix.alpha_in <= a;
        do
            @(posedge clk);
        while (!pix.ready);
    endtask

    // Alpha skewed toward the ignore threshold
    task automatic send_random_pixels(input int count);
        logic [aamd_pkg::CH_W-1:0] a;
        repeat (count) begin
            case ($urandom_range(0, 3))
                0:       a = aamd_pkg::CH_W'($urandom_range(0, aamd_pkg::ALPHA_LIMIT - 1));
                1:       a = aamd_pkg::CH_W'($urandom_range(aamd_pkg::ALPHA_LIMIT - 2,
                                                            aamd_pkg::ALPHA_LIMIT + 1));
                default: a = aamd_pkg::CH_W'($urandom_range(0, 255));
            endcase
            send_pixel(aamd_pkg::CH_W'($urandom_range(0, 255)),
                       aamd_pkg::CH_W'($urandom_range(0, 255)),
                       aamd_pkg::CH_W'($urandom_range(0, 255)), a);
        end
    endtask

    // Drop valid, drain every expected result, then let the pipeline empty
    task automatic settle();
        pix.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_size(input logic [aamd_pkg::DIM_W-1:0] w,
                            input logic [aamd_pkg::DIM_W-1:0] h);
        settle();
        wr_en <= 1'b1;
        wr_index <= aamd_pkg::REG_WIDTH;
        wr_data <= w;
        @(posedge clk);
        wr_index <= aamd_pkg::REG_HEIGHT;
        wr_data <= h;
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_reset_size();
        src_gaps = 1'b1;
        sink_gaps = 1'b1;
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_box_filter();
        set_size(2, 2);
        // all used, full scale
        send_pixel(255, 255, 255, 255);
        send_pixel(255, 255, 255, 255);
        send_pixel(255, 255, 255, 255);
        send_pixel(255, 255, 255, 255);
        // none used, alpha just under the threshold
        send_pixel(255, 255, 255, 15);
        send_pixel(255, 255, 255, 15);
        send_pixel(255, 255, 255, 15);
        send_pixel(255, 255, 255, 15);
        // three used
        send_pixel(10, 20, 30, 16);
        send_pixel(0, 0, 0, 0);
        send_pixel(200, 100, 50, 255);
        send_pixel(255, 255, 255, 16);
        // two used
        send_pixel(255, 0, 255, 200);
        send_pixel(0, 255, 0, 15);
        send_pixel(1, 2, 3, 0);
        send_pixel(254, 255, 0, 100);
        // one used
        send_pixel(7, 8, 9, 255);
        send_pixel(255, 255, 255, 3);
        send_pixel(0, 0, 0, 0);
        send_pixel(128, 128, 128, 15);
    endtask

    task automatic test_thin_images();
        set_size(1, 2);
        send_pixel(0, 0, 0, 0);
        send_pixel(0, 0, 0, 0);
        set_size(2, 1);
        send_pixel(255, 255, 255, 255);
        send_pixel(0, 0, 0, 0);
    endtask

    task automatic test_out_of_range_sizes();
        set_size(0, 5);
        send_random_pixels(5);
        set_size(6, 0);
        send_random_pixels(6);
        set_size(0, 0);
        send_random_pixels(3);
        // widest and tallest images, clamped from all-ones
        src_gaps = 1'b0;
        set_size(8191, 2);
        send_random_pixels(64);
        set_size(2, 8191);
        send_random_pixels(64);
        src_gaps = 1'b1;
    endtask

    // Hold results off while pixels keep coming so the input stalls
    task automatic test_backpressure();
        set_size(8, 4);
        src_gaps = 1'b0;
        sink_gaps = 1'b0;
        stall_request = STALL_STRETCH;
        send_random_pixels(3 * 8 * 4);
        src_gaps = 1'b1;
        sink_gaps = 1'b1;
    endtask

    task automatic test_random_frames();
        int sent;
        int w;
        int h;
        int n;
        int frames;
        sent = 0;
        while (sent < 800) begin
            src_gaps = $urandom_range(0, 3) != 0;
            sink_gaps = $urandom_range(0, 3) != 0;
            case ($urandom_range(0, 7))
                0: begin
                    w = 1;
                    h = $urandom_range(1, 9);
                end
                1: begin
                    w = $urandom_range(1, 9);
                    h = 1;
                end
                default: begin
                    w = $urandom_range(2, 16);
                    h = $urandom_range(2, 8);
                end
            endcase
            set_size(aamd_pkg::DIM_W'(w), aamd_pkg::DIM_W'(h));
            frames = $urandom_range(1, 3);
            // several whole frames back to back, sometimes cut short
            for (int f = 0; f < frames; f++) begin
                n = w * h;
                if ($urandom_range(0, 7) == 0)
                    n = $urandom_range(1, w * h);
                send_random_pixels(n);
                sent += n;
                if (n != w * h)
                    break;
            end
        end
    endtask

    initial begin
        rst_n <= 1'b0;
        wr_en <= 1'b0;
        wr_index <= aamd_pkg::REG_WIDTH;
        wr_data <= '0;
        pix.valid <= 1'b0;
        pix.red_in <= '0;
        pix.green_in <= '0;
        pix.blue_in <= '0;
        pix.alpha_in <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_size();
        test_box_filter();
        test_thin_images();
        test_out_of_range_sizes();
        test_backpressure();
        test_random_frames();

        // Drain, then give the pipeline time to show any stray result
        pix.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/aamd_pkg.sv
hdl/aamd_if.sv
hdl/aamd_front.sv
hdl/aamd_queue.sv
hdl/aamd_back.sv
hdl/alpha_aware_mipmap_downsample.sv
sim/tb.sv
